/* rtl/core/skyline_key_points_core_assert.svh */
// Assertion macros for the skyline key point core.
// Depends on nothing; included by the top level only.
`ifndef SKYLINE_KEY_POINTS_CORE_ASSERT_SVH
`define SKYLINE_KEY_POINTS_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SKP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("skyline core assertion failed");
`define SKP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("skyline core assertion failed");
`else
`define SKP_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define SKP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/skp_pkg.sv */
// Shared types for the skyline key point core: building record, controller
// states and the command/status groups between controller and datapath.
`default_nettype none
package skp_pkg;

  localparam int unsigned XW = 16;

  // One stored building, left edge in the lowest bits.
  typedef struct packed {
    logic [XW-1:0] height;
    logic [XW-1:0] right;
    logic [XW-1:0] left;
  } bldg_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_EVAL,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic accept;     // take the input beat
    logic scan_step;  // visit one stored building
    logic eval;       // close a scan, decide on a key point
    logic flush;      // release the held point as the last one, end the set
  } cmd_t;

  typedef struct packed {
    logic in_last;
    logic scan_done;
    logic init;
    logic found;
    logic emit;
    logic have_pend;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

/* rtl/core/skyline_key_points_core.sv */
// Skyline key point core: top level joining controller and datapath.
// Depends on skp_pkg, skp_ctrl, skp_datapath and the assertion macro header.
//
// Buildings arrive one beat each on the in_ stream, one per cycle while
// in_tready is high, and are kept in a register store of MAX_BLDGS entries;
// beyond that they are dropped and every key point of the set carries
// out_tuser = 1. The beat with in_tlast set closes the set, and in_tready then
// stays low until the set's last key point has been placed in the output
// register. The skyline is found by repeated scans of the store, one building
// per cycle: an opening scan finds the smallest edge, and each later scan
// takes the covering height at the current coordinate and, in the same pass,
// the next larger edge, so the store is scanned again for every distinct edge
// value. The one-building-per-cycle store scan thus sets the compute time of
// a set, which grows with the number of stored buildings and of distinct edge
// values, and output stalls add to it. A key point is held back one step so
// that the final one can be marked with out_tlast; the results stream out
// through a single output register, and no memory needs clearing after reset.
`default_nettype none
`include "skyline_key_points_core_assert.svh"
module skyline_key_points_core
  import skp_pkg::*;
#(
  parameter int unsigned MAX_BLDGS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream: one building per beat
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // left_edge[15:0], right_edge[31:16], bldg_height[47:32]
  input  wire logic        in_tlast,   // last_building
  // result stream: one key point per beat
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // point_x[15:0], point_height[31:16]
  output logic             out_tlast,  // last_point
  output logic             out_tuser   // overflowed
);

  cmd_t    cmd;
  status_t st;

  skp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .st        (st),
    .cmd       (cmd),
    .in_tready (in_tready)
  );

  skp_datapath #(
    .MAX_BLDGS (MAX_BLDGS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // A push into the output register must never overwrite an untaken beat.
  `SKP_ASSERT_NOW(a_push_needs_room, clk, rst_n, (cmd.flush || (cmd.eval && st.emit && st.have_pend)), st.out_free)
  // While loading, only the closing point of the previous set may wait.
  `SKP_ASSERT_NOW(a_load_only_last_waits, clk, rst_n, (in_tready && out_tvalid), out_tlast)
  // A beat that is not taken holds its value until it is.
  `SKP_ASSERT_NEXT(a_hold_until_taken, clk, rst_n, (out_tvalid && !out_tready), (out_tvalid && $stable({out_tdata, out_tlast, out_tuser})))

endmodule
`default_nettype wire

/* rtl/core/skp_ctrl.sv */
// Controller state machine of the skyline key point core.
// Depends on skp_pkg; drives commands into skp_datapath.
`default_nettype none
module skp_ctrl
  import skp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_tvalid,
  input  wire status_t st,
  output cmd_t         cmd,
  output logic         in_tready
);

  state_t state_r, state_nxt;

  // an emitted point pushes the held one out; that needs a free output slot
  logic eval_blocked;
  assign eval_blocked = st.emit && st.have_pend && !st.out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_tvalid && st.in_last) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (st.scan_done) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (!eval_blocked) begin
          if (st.init || st.found) state_nxt = ST_SCAN;
          else state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (st.out_free) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      ST_SCAN:  cmd.scan_step = 1'b1;
      ST_EVAL:  cmd.eval      = !eval_blocked;
      ST_FLUSH: cmd.flush     = st.out_free;
      default: begin
        cmd       = '0;
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/skp_datapath.sv */
// Datapath of the skyline key point core: building store, scan unit,
// held key point and output register. Depends on skp_pkg; driven by skp_ctrl.
`default_nettype none
module skp_datapath
  import skp_pkg::*;
#(
  parameter int unsigned MAX_BLDGS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  output status_t          st,
  input  wire logic [47:0] in_tdata,
  input  wire logic        in_tlast,
  input  wire logic        out_tready,
  output logic             out_tvalid,
  output logic [31:0]      out_tdata,
  output logic             out_tlast,
  output logic             out_tuser
);

  localparam int unsigned CNT_W = $clog2(MAX_BLDGS + 1);
  localparam int unsigned IDX_W = (MAX_BLDGS > 1) ? $clog2(MAX_BLDGS) : 1;

  bldg_t store_r [MAX_BLDGS];

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic             ovf_r, ovf_nxt;
  logic             init_r, init_nxt;
  logic             found_r, found_nxt;
  logic             have_pend_r, have_pend_nxt;
  logic [XW-1:0]    cur_x_r, cur_x_nxt;
  logic [XW-1:0]    nxt_x_r, nxt_x_nxt;
  logic [XW-1:0]    best_r, best_nxt;
  logic [XW-1:0]    prev_r, prev_nxt;
  logic [XW-1:0]    pend_x_r, pend_x_nxt;
  logic [XW-1:0]    pend_h_r, pend_h_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [XW-1:0]    out_x_r, out_x_nxt;
  logic [XW-1:0]    out_h_r, out_h_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  bldg_t         in_bldg;
  bldg_t         rd;
  logic          count_full;
  logic          covers;
  logic          left_ok, right_ok;
  logic [XW-1:0] cand_m1, cand_m2;
  logic          cand_f1, cand_f2;
  logic          emit_w;
  logic          out_free;

  assign in_bldg    = bldg_t'(in_tdata);
  assign rd         = store_r[k_r[IDX_W-1:0]];
  assign count_full = (count_r == CNT_W'(MAX_BLDGS));
  assign out_free   = !out_valid_r || out_tready;
  assign emit_w     = !init_r && (!have_pend_r || (best_r != prev_r));

  // candidate for the next coordinate: smallest edge above the current one,
  // or smallest edge of all on the opening scan
  assign covers   = (rd.left <= cur_x_r) && (cur_x_r < rd.right);
  assign left_ok  = init_r || (rd.left > cur_x_r);
  assign right_ok = init_r || (rd.right > cur_x_r);

  always_comb begin
    cand_m1 = nxt_x_r;
    cand_f1 = found_r;
    if (left_ok && (!found_r || (rd.left < nxt_x_r))) begin
      cand_m1 = rd.left;
      cand_f1 = 1'b1;
    end
    cand_m2 = cand_m1;
    cand_f2 = cand_f1;
    if (right_ok && (!cand_f1 || (rd.right < cand_m1))) begin
      cand_m2 = rd.right;
      cand_f2 = 1'b1;
    end
  end

  always_comb begin
    count_nxt     = count_r;
    k_nxt         = k_r;
    ovf_nxt       = ovf_r;
    init_nxt      = init_r;
    found_nxt     = found_r;
    have_pend_nxt = have_pend_r;
    cur_x_nxt     = cur_x_r;
    nxt_x_nxt     = nxt_x_r;
    best_nxt      = best_r;
    prev_nxt      = prev_r;
    pend_x_nxt    = pend_x_r;
    pend_h_nxt    = pend_h_r;
    out_valid_nxt = out_valid_r;
    out_x_nxt     = out_x_r;
    out_h_nxt     = out_h_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    if (cmd.accept) begin
      if (!count_full) count_nxt = count_r + CNT_W'(1);
      else ovf_nxt = 1'b1;
      if (in_tlast) begin
        init_nxt  = 1'b1;
        k_nxt     = '0;
        best_nxt  = '0;
        found_nxt = 1'b0;
      end
    end

    if (cmd.scan_step) begin
      if (covers && (rd.height > best_r)) best_nxt = rd.height;
      nxt_x_nxt = cand_m2;
      found_nxt = cand_f2;
      k_nxt     = k_r + CNT_W'(1);
    end

    if (cmd.eval) begin
      if (emit_w) begin
        // release the held point, hold the new one until its successor is known
        if (have_pend_r) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = pend_x_r;
          out_h_nxt     = pend_h_r;
          out_last_nxt  = 1'b0;
          out_ovf_nxt   = ovf_r;
        end
        pend_x_nxt    = cur_x_r;
        pend_h_nxt    = best_r;
        have_pend_nxt = 1'b1;
        prev_nxt      = best_r;
      end
      cur_x_nxt = nxt_x_r;
      init_nxt  = 1'b0;
      k_nxt     = '0;
      best_nxt  = '0;
      found_nxt = 1'b0;
    end

    if (cmd.flush) begin
      out_valid_nxt = 1'b1;
      out_x_nxt     = pend_x_r;
      out_h_nxt     = pend_h_r;
      out_last_nxt  = 1'b1;
      out_ovf_nxt   = ovf_r;
      have_pend_nxt = 1'b0;
      count_nxt     = '0;
      ovf_nxt       = 1'b0;
      prev_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && !count_full) store_r[count_r[IDX_W-1:0]] <= in_bldg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      k_r         <= '0;
      ovf_r       <= 1'b0;
      init_r      <= 1'b0;
      found_r     <= 1'b0;
      have_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
      prev_r      <= '0;
    end else begin
      count_r     <= count_nxt;
      k_r         <= k_nxt;
      ovf_r       <= ovf_nxt;
      init_r      <= init_nxt;
      found_r     <= found_nxt;
      have_pend_r <= have_pend_nxt;
      out_valid_r <= out_valid_nxt;
      prev_r      <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r    <= cur_x_nxt;
    nxt_x_r    <= nxt_x_nxt;
    best_r     <= best_nxt;
    pend_x_r   <= pend_x_nxt;
    pend_h_r   <= pend_h_nxt;
    out_x_r    <= out_x_nxt;
    out_h_r    <= out_h_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign st.in_last   = in_tlast;
  assign st.scan_done = (k_r == (count_r - CNT_W'(1)));
  assign st.init      = init_r;
  assign st.found     = found_r;
  assign st.emit      = emit_w;
  assign st.have_pend = have_pend_r;
  assign st.out_free  = out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_h_r, out_x_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

endmodule
`default_nettype wire

/* tb/tb_skyline_key_points_core.sv */
// Self-checking testbench for skyline_key_points_core: drives building beats,
// predicts the key points of every set and checks each result beat in order.
// Depends on skp_pkg and the skyline_key_points_core RTL.
`timescale 1ns / 100ps
module tb_skyline_key_points_core;
  import skp_pkg::*;

  localparam int unsigned MAX_BLDGS = 16;
  localparam int unsigned RANDOM_ITEMS = 164;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 700;

  // One key point as it leaves the block.
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] h;
    logic        last;
    logic        ovf;
  } key_point_t;

  // One directed row: a building sent rep times, tlast on the final copy only.
  // n_typed > 0 means the set's key points are written out in t0/t1.
  typedef struct packed {
    logic [5:0] rep;
    bldg_t      bld;
    logic       last;
    logic [1:0] n_typed;
    key_point_t t0;
    key_point_t t1;
  } stim_row_t;

  localparam key_point_t KP_NONE = '0;
  localparam int unsigned N_ROWS = 20;

  // bldg_t positional order is height, right, left.
  stim_row_t directed_tab [N_ROWS] = '{
    // full-width building at maximum height
    '{6'd1, '{16'd65535, 16'd65535, 16'd0}, 1'b1, 2'd2,
      '{16'd0, 16'd65535, 1'b0, 1'b0}, '{16'd65535, 16'd0, 1'b1, 1'b0}},
    // all-zero building
    '{6'd1, '{16'd0, 16'd0, 16'd0}, 1'b1, 2'd1,
      '{16'd0, 16'd0, 1'b1, 1'b0}, KP_NONE},
    // inverted building: right below left
    '{6'd1, '{16'd7, 16'd50, 16'd100}, 1'b1, 2'd1,
      '{16'd50, 16'd0, 1'b1, 1'b0}, KP_NONE},
    // zero height
    '{6'd1, '{16'd0, 16'd20, 16'd10}, 1'b1, 2'd1,
      '{16'd10, 16'd0, 1'b1, 1'b0}, KP_NONE},
    // empty building: right equals left
    '{6'd1, '{16'd9, 16'd30, 16'd30}, 1'b1, 2'd1,
      '{16'd30, 16'd0, 1'b1, 1'b0}, KP_NONE},
    // narrowest building at the top of the coordinate range
    '{6'd1, '{16'd1, 16'd65535, 16'd65534}, 1'b1, 2'd2,
      '{16'd65534, 16'd1, 1'b0, 1'b0}, '{16'd65535, 16'd0, 1'b1, 1'b0}},
    // overlapping trio
    '{6'd1, '{16'd10, 16'd9, 16'd2}, 1'b0, 2'd0, KP_NONE, KP_NONE},
    '{6'd1, '{16'd15, 16'd7, 16'd3}, 1'b0, 2'd0, KP_NONE, KP_NONE},
    '{6'd1, '{16'd12, 16'd12, 16'd5}, 1'b1, 2'd0, KP_NONE, KP_NONE},
    // touching buildings of equal height merge into one step
    '{6'd1, '{16'd3, 16'd5, 16'd1}, 1'b0, 2'd0, KP_NONE, KP_NONE},
    '{6'd1, '{16'd3, 16'd9, 16'd5}, 1'b0, 2'd0, KP_NONE, KP_NONE},
    '{6'd1, '{16'd3, 16'd13, 16'd9}, 1'b1, 2'd0, KP_NONE, KP_NONE},
    // lower building nested inside a full-width one
    '{6'd1, '{16'd65535, 16'd65535, 16'd0}, 1'b0, 2'd0, KP_NONE, KP_NONE},
    '{6'd1, '{16'd43690, 16'd43690, 16'd21845}, 1'b1, 2'd0, KP_NONE, KP_NONE},
    // store filled exactly, no drop
    '{6'd16, '{16'd100, 16'd8, 16'd7}, 1'b1, 2'd0, KP_NONE, KP_NONE},
    // one beyond capacity: the final building itself is dropped
    '{6'd17, '{16'd5, 16'd50000, 16'd40000}, 1'b1, 2'd0, KP_NONE, KP_NONE},
    // capacity exceeded over a mixed set
    '{6'd15, '{16'd3, 16'd2, 16'd1}, 1'b0, 2'd0, KP_NONE, KP_NONE},
    '{6'd1, '{16'd6, 16'd5, 16'd4}, 1'b0, 2'd0, KP_NONE, KP_NONE},
    '{6'd2, '{16'd9, 16'd61000, 16'd60000}, 1'b1, 2'd0, KP_NONE, KP_NONE},
    // alternating bit patterns, inverted edges
    '{6'd1, '{16'h5555, 16'h5555, 16'hAAAA}, 1'b1, 2'd0, KP_NONE, KP_NONE}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // left_edge[15:0], right_edge[31:16], bldg_height[47:32]
  logic        in_tlast;   // last_building
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // point_x[15:0], point_height[31:16]
  logic        out_tlast;  // last_point
  logic        out_tuser;  // overflowed

  // Predictor state: the set being gathered and whether any of it was dropped.
  bldg_t      set_bldgs [$];
  logic       set_dropped = 1'b0;
  key_point_t expected_points [$];
  int         mismatches = 0;
  int         points_seen = 0;
  bit         long_hold_done = 1'b0;

  skyline_key_points_core #(
    .MAX_BLDGS (MAX_BLDGS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #2 clk = ~clk;

  // Tallest stored building covering x, zero where nothing covers it.
  function automatic logic [15:0] skyline_height_at(logic [15:0] x);
    logic [15:0] best;
    best = '0;
    foreach (set_bldgs[k]) begin
      if (set_bldgs[k].left <= x && x < set_bldgs[k].right && set_bldgs[k].height > best)
        best = set_bldgs[k].height;
    end
    return best;
  endfunction

  // Sort all edges of the gathered set and queue a key point at every
  // height change, the first edge always included.
  function automatic void predict_skyline();
    logic [15:0] edges [$];
    logic [15:0] v;
    logic [15:0] hgt;
    logic [15:0] prev;
    key_point_t  pts [$];
    key_point_t  pt;
    int          j;
    foreach (set_bldgs[k]) begin
      edges.push_back(set_bldgs[k].left);
      edges.push_back(set_bldgs[k].right);
    end
    for (int i = 1; i < edges.size(); i++) begin
      v = edges[i];
      j = i;
      while (j > 0 && edges[j-1] > v) begin
        edges[j] = edges[j-1];
        j--;
      end
      edges[j] = v;
    end
    prev = '0;
    foreach (edges[k]) begin
      hgt = skyline_height_at(edges[k]);
      if (pts.size() == 0 || hgt != prev) begin
        pt = '{x: edges[k], h: hgt, last: 1'b0, ovf: set_dropped};
        pts.push_back(pt);
        prev = hgt;
      end
    end
    if (pts.size() > 0)
      pts[pts.size()-1].last = 1'b1;
    foreach (pts[k])
      expected_points.push_back(pts[k]);
  endfunction

  // Update the predictor with one accepted building beat.
  function automatic void note_building(bldg_t b, logic last, logic [1:0] n_typed,
                                        key_point_t t0, key_point_t t1);
    if (set_bldgs.size() < MAX_BLDGS)
      set_bldgs.push_back(b);
    else
      set_dropped = 1'b1;
    if (last) begin
      if (n_typed != 0) begin
        expected_points.push_back(t0);
        if (n_typed > 1)
          expected_points.push_back(t1);
      end else begin
        predict_skyline();
      end
      set_bldgs = {};
      set_dropped = 1'b0;
    end
  endfunction

  // Offer one building after a random gap and hold it until accepted.
  // tvalid is lowered only when a gap follows, so it never toggles in one step.
  task automatic send_building(bldg_t b, logic last, bit burst, logic [1:0] n_typed,
                               key_point_t t0, key_point_t t1);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    note_building(b, last, n_typed, t0, t1);
  endtask

  // Receiver: random stalls, calm stretches, and one long hold-off that
  // lets the block fill up and refuse input.
  initial begin
    int          stall;
    bit          calm;
    key_point_t  got;
    key_point_t  want;
    calm = 1'b0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0)
        calm = ~calm;
      stall = calm ? 0 : $urandom_range(0, 8);
      if (!long_hold_done && points_seen == 50) begin
        long_hold_done = 1'b1;
        stall = LONG_HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got = '{x: out_tdata[15:0], h: out_tdata[31:16], last: out_tlast, ovf: out_tuser};
      points_seen++;
      if (expected_points.size() == 0) begin
        $error("key point x=%0d h=%0d arrived with no expectation waiting", got.x, got.h);
        mismatches++;
      end else begin
        want = expected_points.pop_front();
        if (got.x !== want.x) begin
          $error("point_x: expected %0d, got %0d", want.x, got.x);
          mismatches++;
        end
        if (got.h !== want.h) begin
          $error("point_height: expected %0d, got %0d", want.h, got.h);
          mismatches++;
        end
        if (got.last !== want.last) begin
          $error("last_point: expected %0d, got %0d", want.last, got.last);
          mismatches++;
        end
        if (got.ovf !== want.ovf) begin
          $error("overflowed: expected %0d, got %0d", want.ovf, got.ovf);
          mismatches++;
        end
      end
    end
  end

  // Stimulus: directed table first, then random sets, then drain and report.
  initial begin
    bldg_t      b;
    stim_row_t  row;
    int         random_items;
    int         set_index;
    int         set_size;
    bit         burst;
    random_items = 0;
    set_index = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table; typed rows bypass the predictor.
    for (int r = 0; r < N_ROWS; r++) begin
      row = directed_tab[r];
      for (int c = 0; c < row.rep; c++)
        send_building(row.bld, row.last && (c == row.rep - 1), 1'b0,
                      row.n_typed, row.t0, row.t1);
    end

    // Random sets: mostly well-formed buildings, some noise; now and then
    // a set larger than the store.
    while (random_items < RANDOM_ITEMS) begin
      set_size = ($urandom_range(0, 7) == 0) ? $urandom_range(MAX_BLDGS + 1, MAX_BLDGS + 4)
                                             : $urandom_range(1, 12);
      burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < set_size; i++) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            // noise: any edges, any height, inverted and empty included
            b.left   = 16'($urandom_range(0, 65535));
            b.right  = 16'($urandom_range(0, 65535));
            b.height = 16'($urandom_range(0, 65535));
          end
          2, 3, 4, 5: begin
            // crowded: small coordinates and few heights give ties and merges
            b.left   = 16'($urandom_range(0, 62));
            b.right  = 16'($urandom_range(b.left + 1, 63));
            b.height = 16'($urandom_range(1, 8));
          end
          default: begin
            b.left   = 16'($urandom_range(0, 65534));
            b.right  = 16'($urandom_range(b.left + 1, 65535));
            b.height = 16'($urandom_range(1, 65535));
          end
        endcase
        send_building(b, i == set_size - 1, burst, 2'd0, KP_NONE, KP_NONE);
        random_items++;
      end
      set_index++;
      // once: hold the input back until every key point has come out
      if (set_index == 8) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (expected_points.size() != 0);
      end
    end

    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    // allow any stray beat time to show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("tb_skyline_key_points_core OK");
    end else begin
      $display("tb_skyline_key_points_core NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #4ms;
    $display("tb_skyline_key_points_core NOT OK");
    $finish;
  end

endmodule
